/* design/ess_pkg.sv */
// Shared types, constants and step functions for the ellipse scanline span block.
// Used by every module under design/; depends on nothing else.
package ess_pkg;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS_X = 2'd2,
        REG_RADIUS_Y = 2'd3
    } t_reg_idx;

    localparam int unsigned RX_LIMIT = 512;
    localparam int unsigned RY_LIMIT = 256;

    // pipeline layout
    localparam int unsigned NSTG     = 11;
    localparam int unsigned ST_SQRT0 = 3;
    localparam int unsigned ST_PROD  = 6;
    localparam int unsigned ST_DIV0  = 7;
    localparam int unsigned ST_OUT   = 10;

    typedef struct packed {
        logic signed [10:0] center_x;
        logic signed [10:0] center_y;
        logic [9:0]         radius_x;
        logic [8:0]         radius_y;
    } t_cfg;

    typedef struct packed {
        logic win;
        logic err;
    } t_flags;

    // partial state of the bit-by-bit square root
    typedef struct packed {
        logic [17:0] v;
        logic [17:0] r;
    } t_sq;

    // partial state of the restoring divider
    typedef struct packed {
        logic [17:0] rem;
        logic [9:0]  q;
    } t_dv;

    // one root step at bit weight 4**k
    function automatic t_sq sq_step(t_sq s, logic [3:0] k);
        logic [17:0] b;
        logic [17:0] t;
        t_sq         o;
        b = 18'(1) << {k, 1'b0};
        t = s.r + b;
        if (s.v >= t) begin
            o.v = s.v - t;
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // one quotient bit at weight 2**k
    function automatic t_dv dv_step(t_dv s, logic [8:0] d, logic [3:0] k);
        logic [18:0] ds;
        t_dv         o;
        ds = 19'(d) << k;
        o  = s;
        if ({1'b0, s.rem} >= ds) begin
            o.rem  = s.rem - ds[17:0];
            o.q[k] = 1'b1;
        end
        return o;
    endfunction

endpackage

/* design/ess_cfg.sv */
// APB-style configuration registers: centre and radii of the ellipse.
// Depends on ess_pkg.
module ess_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ess_pkg::t_cfg o_cfg
);
    import ess_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.radius_x <= '0;
            r_cfg.radius_y <= 9'd1;
        end else if (wr) begin
            case (idx)
                REG_CENTER_X: r_cfg.center_x <= pwdata[10:0];
                REG_CENTER_Y: r_cfg.center_y <= pwdata[10:0];
                REG_RADIUS_X: r_cfg.radius_x <= pwdata[9:0];
                REG_RADIUS_Y: r_cfg.radius_y <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_X: prdata = {21'b0, r_cfg.center_x};
            REG_CENTER_Y: prdata = {21'b0, r_cfg.center_y};
            REG_RADIUS_X: prdata = {22'b0, r_cfg.radius_x};
            REG_RADIUS_Y: prdata = {23'b0, r_cfg.radius_y};
            default:      prdata = '0;
        endcase
    end

endmodule

/* design/ess_front.sv */
// Front stages: window test and |dy|, the two squares, then ry^2 - dy^2.
// Depends on ess_pkg.
module ess_front #(
    parameter int MAX_Y = 511
) (
    input  logic            i_clk,
    input  logic [2:0]      i_en,
    input  logic [8:0]      i_row,
    input  ess_pkg::t_cfg   i_cfg,
    output ess_pkg::t_flags o_flg,
    output logic [16:0]     o_inner
);
    import ess_pkg::*;

    localparam logic signed [11:0] MAXY_S = 12'(MAX_Y);

    logic signed [11:0] cy;
    logic signed [11:0] ry;
    logic signed [11:0] rs;
    logic signed [11:0] top;
    logic signed [11:0] top_c;
    logic signed [11:0] bottom;
    logic signed [11:0] dy;
    logic [11:0]        ady;
    logic               err;
    logic [17:0]        n_r2;
    logic [17:0]        n_d2;

    t_flags      r_flg;
    logic [8:0]  r_ady;
    logic [16:0] r_r2;
    logic [16:0] r_d2;
    logic [16:0] r_inner;

    always_comb begin
        cy     = {i_cfg.center_y[10], i_cfg.center_y};
        ry     = $signed({3'b0, i_cfg.radius_y});
        rs     = $signed({3'b0, i_row});
        top    = cy - ry;
        bottom = cy + ry;
        top_c  = (top < 0) ? 12'sd0 : top;
        err    = (i_cfg.radius_y == 9'd0) || (i_cfg.radius_y > 9'(RY_LIMIT))
              || (i_cfg.radius_x > 10'(RX_LIMIT)) || (bottom < 0) || (bottom > MAXY_S);
        dy     = rs - cy;
        ady    = (dy < 0) ? 12'(-dy) : 12'(dy);
        n_r2   = {9'b0, i_cfg.radius_y} * {9'b0, i_cfg.radius_y};
        n_d2   = {9'b0, r_ady} * {9'b0, r_ady};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_flg.err <= err;
            r_flg.win <= !err && (rs >= top_c) && (rs <= bottom);
            // only meaningful inside the window, where |dy| <= ry <= 256
            r_ady     <= ady[8:0];
        end
        if (i_en[1]) begin
            r_r2 <= n_r2[16:0];
            r_d2 <= n_d2[16:0];
        end
        if (i_en[2]) begin
            r_inner <= (r_r2 > r_d2) ? (r_r2 - r_d2) : 17'd0;
        end
    end

    assign o_flg   = r_flg;
    assign o_inner = r_inner;

endmodule

/* design/ess_sqrt.sv */
// Pipelined bit-by-bit integer square root of a 17-bit value, three steps per stage.
// Depends on ess_pkg.
module ess_sqrt (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [16:0] i_inner,
    output logic [8:0]  o_root
);
    import ess_pkg::*;

    t_sq r_sq [3];
    t_sq n_sq [3];

    always_comb begin
        t_sq s;
        for (int g = 0; g < 3; g++) begin
            if (g == 0) begin
                s.v = {1'b0, i_inner};
                s.r = '0;
            end else begin
                s = r_sq[g-1];
            end
            for (int j = 0; j < 3; j++) begin
                s = sq_step(s, 4'(8 - 3 * g - j));
            end
            n_sq[g] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 3; g++) begin
            if (i_en[g]) begin
                r_sq[g] <= n_sq[g];
            end
        end
    end

    assign o_root = r_sq[2].r[8:0];

endmodule

/* design/ess_div.sv */
// Pipelined restoring divider: 18-bit dividend by 9-bit divisor, 10 quotient bits.
// Depends on ess_pkg.
module ess_div (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [17:0] i_num,
    input  logic [8:0]  i_den,
    output logic [9:0]  o_quo
);
    import ess_pkg::*;

    t_dv r_dv [3];
    t_dv n_dv [3];

    always_comb begin
        t_dv s;
        s.rem = i_num;
        s.q   = '0;
        for (int j = 0; j < 4; j++) begin
            s = dv_step(s, i_den, 4'(9 - j));
        end
        n_dv[0] = s;
        s = r_dv[0];
        for (int j = 0; j < 3; j++) begin
            s = dv_step(s, i_den, 4'(5 - j));
        end
        n_dv[1] = s;
        s = r_dv[1];
        for (int j = 0; j < 3; j++) begin
            s = dv_step(s, i_den, 4'(2 - j));
        end
        n_dv[2] = s;
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 3; g++) begin
            if (i_en[g]) begin
                r_dv[g] <= n_dv[g];
            end
        end
    end

    assign o_quo = r_dv[2].q;

endmodule

/* design/ellipse_scanline_span.sv */
// Ellipse scanline span: for each requested row, the clamped left and right
// edge of a filled ellipse set up over an APB-style register port.
// Input channel: i_valid / o_stall with i_row. Output channel: o_valid /
// i_stall with o_left_x, o_right_x, o_in_window, o_config_error.
// Registers at paddr 0x0 center_x, 0x4 center_y, 0x8 radius_x, 0xC radius_y;
// write them only while no row is in flight.
// The pipeline has 11 register stages: window test, squares, difference,
// three root stages, the rx*root product, three divider stages and the edge
// clamp. One row is taken every cycle while the output side keeps up.
// Each stage has a valid bit and moves when the stage after it is empty or
// moving, so bubbles close up and a row can still enter while a result waits.
// When the receiver stalls, the result holds and the stages fill behind it;
// o_stall rises once the first stage is occupied and cannot move.
// Reset clears all valid bits and sets the registers to centre 0,0,
// radius_x 0 and radius_y 1.
module ellipse_scanline_span #(
    parameter int MAX_X = 703,
    parameter int MAX_Y = 511
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_left_x,
    output logic [9:0]  o_right_x,
    output logic        o_in_window,
    output logic        o_config_error
);
    import ess_pkg::*;

    localparam logic signed [11:0] MAXX_S = 12'(MAX_X);

    t_cfg              cfg;
    t_flags            flg0;
    logic [16:0]       inner;
    logic [8:0]        root;
    logic [9:0]        dx;
    logic [NSTG-1:0]   en;
    logic [NSTG-1:0]   n_vld;
    logic signed [11:0] cx;
    logic signed [11:0] lx;
    logic signed [11:0] rx;
    logic [19:0]       n_prod;

    logic [NSTG-1:0]   r_vld;
    t_flags            r_flg [1:NSTG-1];
    logic [17:0]       r_prod;
    logic [9:0]        r_left;
    logic [9:0]        r_right;

    function automatic logic [9:0] clamp_x(logic signed [11:0] x);
        if (x < 0) begin
            return 10'd0;
        end
        if (x > MAXX_S) begin
            return 10'(MAX_X);
        end
        return x[9:0];
    endfunction

    ess_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ess_front #(.MAX_Y(MAX_Y)) u_front (
        .i_clk   (i_clk),
        .i_en    (en[2:0]),
        .i_row   (i_row),
        .i_cfg   (cfg),
        .o_flg   (flg0),
        .o_inner (inner)
    );

    ess_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_en    (en[ST_SQRT0 +: 3]),
        .i_inner (inner),
        .o_root  (root)
    );

    ess_div u_div (
        .i_clk (i_clk),
        .i_en  (en[ST_DIV0 +: 3]),
        .i_num (r_prod),
        .i_den (cfg.radius_y),
        .o_quo (dx)
    );

    // a stage loads when it is empty or the next one moves on
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = {r_vld[NSTG-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_flg[1] <= flg0;
        end
        for (int k = 2; k < NSTG; k++) begin
            if (en[k]) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    always_comb begin
        n_prod = {10'b0, cfg.radius_x} * {11'b0, root};
        cx     = {cfg.center_x[10], cfg.center_x};
        lx     = cx - $signed({2'b0, dx});
        rx     = cx + $signed({2'b0, dx});
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_PROD]) begin
            r_prod <= n_prod[17:0];
        end
        if (en[ST_OUT]) begin
            r_left  <= r_flg[ST_OUT-1].win ? clamp_x(lx) : 10'd0;
            r_right <= r_flg[ST_OUT-1].win ? clamp_x(rx) : 10'd0;
        end
    end

    assign o_stall        = !en[0];
    assign o_valid        = r_vld[ST_OUT];
    assign o_left_x       = r_left;
    assign o_right_x      = r_right;
    assign o_in_window    = r_flg[ST_OUT].win;
    assign o_config_error = r_flg[ST_OUT].err;

    a_win_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_in_window && o_config_error))
        else $error("row in window under a bad configuration");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_window) |-> (o_left_x == 10'd0 && o_right_x == 10'd0))
        else $error("span not zero outside the window");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_x <= o_right_x))
        else $error("left edge beyond right edge");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0])
        else $error("input stalled with an empty first stage");

endmodule

/* verif/ess_span_checker.sv */
// Scoreboard for ellipse_scanline_span: mirrors the register writes, predicts the
// span of every row transfer and compares the result transfers in order.
// Depends on ess_pkg for the register map, the config layout and the radius limits.
module ess_span_checker #(
    parameter int MAX_X = 703,
    parameter int MAX_Y = 511
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [8:0]  i_row,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [9:0]  o_left_x,
    input  logic [9:0]  o_right_x,
    input  logic        o_in_window,
    input  logic        o_config_error,
    output int          o_fail_count,
    output int          o_pending
);
    import ess_pkg::*;

    typedef struct packed {
        logic [9:0] left_x;
        logic [9:0] right_x;
        logic       in_window;
        logic       config_error;
    } t_span;

    t_cfg  cfg;
    t_span spans_due[$];

    function automatic logic [9:0] clamp_edge(int x);
        if (x < 0) return '0;
        if (x > MAX_X) return 10'(MAX_X);
        return 10'(x);
    endfunction

    // bit-by-bit root, one trial subtraction per bit pair
    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned root;
        int unsigned weight;
        int unsigned trial;
        root   = 0;
        weight = 32'd1 << 30;
        while (weight != 0) begin
            trial = root + weight;
            if (v >= trial) begin
                v    = v - trial;
                root = (root >> 1) + weight;
            end else begin
                root = root >> 1;
            end
            weight = weight >> 2;
        end
        return root;
    endfunction

    function automatic t_span predict_span(t_cfg c, logic [8:0] row);
        int          cx;
        int          cy;
        int          top;
        int          bottom;
        int          dy;
        int unsigned rx;
        int unsigned ry;
        int unsigned ady;
        int unsigned inner;
        int unsigned dx;
        t_span       s;
        cx     = $signed(c.center_x);
        cy     = $signed(c.center_y);
        rx     = c.radius_x;
        ry     = c.radius_y;
        top    = cy - int'(ry);
        bottom = cy + int'(ry);
        s      = '0;
        s.config_error = (ry == 0) || (ry > RY_LIMIT) || (rx > RX_LIMIT) ||
                         (bottom < 0) || (bottom > MAX_Y);
        if (top < 0) top = 0;
        if (!s.config_error && int'(row) >= top && int'(row) <= bottom) begin
            dy    = int'(row) - cy;
            ady   = (dy < 0) ? -dy : dy;
            inner = (ry * ry > ady * ady) ? ry * ry - ady * ady : 0;
            dx    = rx * int_sqrt(inner) / ry;
            s.in_window = 1'b1;
            s.left_x    = clamp_edge(cx - int'(dx));
            s.right_x   = clamp_edge(cx + int'(dx));
        end
        return s;
    endfunction

    task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_span want;
        if (!i_rst_n) begin
            cfg.center_x = '0;
            cfg.center_y = '0;
            cfg.radius_x = '0;
            cfg.radius_y = 9'd1;
            o_fail_count = 0;
        end else begin
            // predict with the settings in force before any write at this edge
            if (i_valid && !o_stall) spans_due.push_back(predict_span(cfg, i_row));
            if (o_valid && !i_stall) begin
                if (spans_due.size() == 0) begin
                    $error("result transfer with no row waiting: left_x %0d right_x %0d",
                           o_left_x, o_right_x);
                    o_fail_count++;
                end else begin
                    want = spans_due.pop_front();
                    check_field("left_x", want.left_x, o_left_x);
                    check_field("right_x", want.right_x, o_right_x);
                    check_field("in_window", 10'(want.in_window), 10'(o_in_window));
                    check_field("config_error", 10'(want.config_error),
                                10'(o_config_error));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_CENTER_X: cfg.center_x = pwdata[10:0];
                    REG_CENTER_Y: cfg.center_y = pwdata[10:0];
                    REG_RADIUS_X: cfg.radius_x = pwdata[9:0];
                    REG_RADIUS_Y: cfg.radius_y = pwdata[8:0];
                    default: ;
                endcase
            end
        end
        o_pending = spans_due.size();
    end

endmodule

/* verif/tb_ellipse_scanline_span.sv */
// Testbench top for ellipse_scanline_span: clock, reset, register writes, row
// stimulus with random idling and the verdict; checking lives in ess_span_checker.
// Depends on ess_pkg, the design under design/ and ess_span_checker.
module tb_ellipse_scanline_span;
    import ess_pkg::*;

    localparam int MAX_X          = 703;
    localparam int MAX_Y          = 511;
    localparam int RX_HOLD        = 80;
    localparam int SETTLE         = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENTS       = 11;
    localparam int SEGMENT_ROWS   = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [8:0]  i_row;
    logic        o_valid;
    logic        i_stall;
    logic [9:0]  o_left_x;
    logic [9:0]  o_right_x;
    logic        o_in_window;
    logic        o_config_error;

    int fail_count;
    int pending;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int row_lo        = 0;
    int row_hi        = -1;

    ellipse_scanline_span #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) i_dut (.*);

    ess_span_checker #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) i_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall, or a long hold-off when one is requested
    initial begin : result_side
        int hold_served;
        int held;
        hold_served = 0;
        i_stall     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                i_stall <= 1'b1;
                for (held = 1; held < RX_HOLD; held++) @(negedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("ellipse_scanline_span: mismatch");
        $finish;
    end

    // all tasks start and end at a falling edge
    task automatic send_row(input logic [8:0] row);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_row   <= row;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_spans();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // psel is left high; the caller drops it after the last write
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_ellipse(input int cx, input int cy, input int rx, input int ry);
        drain_spans();
        repeat (SETTLE) @(negedge i_clk);
        apb_write(REG_CENTER_X, {21'd0, 11'(cx)});
        apb_write(REG_CENTER_Y, {21'd0, 11'(cy)});
        apb_write(REG_RADIUS_X, {22'd0, 10'(rx)});
        apb_write(REG_RADIUS_Y, {23'd0, 9'(ry)});
        psel    <= 1'b0;
        penable <= 1'b0;
        row_lo = (cy - ry < 0) ? 0 : cy - ry;
        row_hi = (cy + ry > 511) ? 511 : cy + ry;
    endtask

    // mostly drawable ellipses, the rest anything the register widths hold
    task automatic random_ellipse();
        int ry;
        if ($urandom_range(99) < 80) begin
            ry = $urandom_range(RY_LIMIT, 1);
            set_ellipse(int'($urandom_range(2047)) - 1024,
                        int'($urandom_range(MAX_Y)) - ry,
                        $urandom_range(RX_LIMIT), ry);
        end else begin
            set_ellipse(int'($urandom_range(2047)) - 1024,
                        int'($urandom_range(2047)) - 1024,
                        $urandom_range(1023), $urandom_range(511));
        end
    endtask

    // rows around the vertical extent, one line beyond each end included, or else any row
    function automatic logic [8:0] pick_row();
        int lo;
        int hi;
        if (row_hi < row_lo || $urandom_range(99) < 30) return 9'($urandom_range(511));
        lo = (row_lo > 0) ? row_lo - 1 : 0;
        hi = (row_hi < 511) ? row_hi + 1 : 511;
        return 9'($urandom_range(hi, lo));
    endfunction

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_row   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // settings out of reset
        send_row(9'd0);
        send_row(9'd1);
        send_row(9'd511);
        // full-height ellipse, top clipped at zero, left edge far off screen
        set_ellipse(-1024, 255, 512, 256);
        send_row(9'd0);
        send_row(9'd1);
        send_row(9'd255);
        send_row(9'd511);
        // centre past the right edge with zero width
        set_ellipse(1023, 0, 0, 1);
        send_row(9'd0);
        send_row(9'd1);
        // bottom below the screen
        set_ellipse(300, 767, 100, 10);
        send_row(9'd500);
        // bad radii
        set_ellipse(300, 100, 100, 0);
        send_row(9'd100);
        set_ellipse(300, 100, 1023, 20);
        send_row(9'd100);
        set_ellipse(300, 100, 513, 20);
        send_row(9'd100);
        set_ellipse(300, 100, 100, 257);
        send_row(9'd100);
        set_ellipse(300, 100, 100, 511);
        send_row(9'd100);
        // bottom above the screen
        set_ellipse(10, -512, 50, 256);
        send_row(9'd0);
        // bottom exactly on line zero
        set_ellipse(10, -1, 50, 1);
        send_row(9'd0);
        send_row(9'd1);
        // bottom on the last line, both edges clamped at the widest row
        set_ellipse(350, 400, 512, 111);
        send_row(9'd288);
        send_row(9'd289);
        send_row(9'd400);
        send_row(9'd511);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct <= 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct <= 31;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                random_ellipse();
                // long hold-off while rows keep coming, so the pipe backs up
                if (ph == 2 && seg == 1) hold_requests <= hold_requests + 1;
                for (int n = 0; n < SEGMENT_ROWS; n++) begin
                    if (ph == 1 && seg == 4 && n == SEGMENT_ROWS / 2) drain_spans();
                    send_row(pick_row());
                end
            end
        end

        drain_spans();
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ellipse_scanline_span: match");
        else
            $display("ellipse_scanline_span: mismatch");
        $finish;
    end

endmodule
